>>> rtl/dsfp_pkg.sv
// ----------------------------------------------------------------------------
// dsfp_pkg: shared types and constants of the dual sync frame parser
// Sizes, sync bytes, parser stage and protocol codes, and the command that
// travels from the front queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfp_pkg;

    localparam int PORTS       = 4;
    localparam int FRAME_BYTES = 256;

    localparam int PORT_W  = 2;                        // port field width
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = $clog2(FRAME_BYTES);      // offset inside a frame
    localparam int WIDX_W  = IDX_W + 1;                // can hold FRAME_BYTES
    localparam int ADDR_W  = PORT_W + IDX_W;           // frame store address
    localparam int STORE_DEPTH = PORTS * FRAME_BYTES;
    localparam int SIZE_W  = 16;
    localparam int LEN_W   = 9;

    localparam logic [BYTE_W-1:0] SYNC_DB_A  = 8'h64;  // 'd'
    localparam logic [BYTE_W-1:0] SYNC_DB_B  = 8'h62;  // 'b'
    localparam logic [BYTE_W-1:0] SYNC_UBX_A = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_UBX_B = 8'h62;

    localparam int FRAME_OVERHEAD = 6;
    localparam logic [SIZE_W-1:0] MAX_PAYLOAD = SIZE_W'(FRAME_BYTES - FRAME_OVERHEAD);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_SYNC2   = 3'd1,
        ST_TYPE0   = 3'd2,
        ST_TYPE1   = 3'd3,
        ST_SIZE    = 3'd4,
        ST_PAYLOAD = 3'd5
    } stage_t;

    typedef enum logic [1:0] {
        PROTO_NONE = 2'd0,
        PROTO_DB   = 2'd1,
        PROTO_UBX  = 2'd2
    } proto_t;

    // One classified request: a received byte or a store read.
    typedef struct packed {
        logic              is_read;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] value;   // received byte or read offset
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/dsfp_ram.sv
// ----------------------------------------------------------------------------
// dsfp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/dsfp_front.sv
// ----------------------------------------------------------------------------
// dsfp_front: input classification and two-entry command queue
// Accepts request beats, folds the byte field that matters into one command,
// and buffers up to two commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_front
    import dsfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // port[1:0], data_byte[9:2], read_index[17:10]
    input  wire logic        s_tuser,   // req_type
    output      logic        q_valid,
    output      cmd_t        q_cmd,
    input  wire logic        q_pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       in_cmd;

    always_comb
    begin
        in_cmd.is_read = s_tuser;
        in_cmd.port    = s_tdata[1:0];
        in_cmd.value   = s_tuser ? s_tdata[17:10] : s_tdata[9:2];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from an empty command queue");

    a_ptr_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/dsfp_back.sv
// ----------------------------------------------------------------------------
// dsfp_back: per-port frame parsers, frame store and result register
// Takes one command per cycle while its result register is free or being emptied,
// updates the addressed port's parser, writes or reads the frame store, and
// holds the result until it is taken.
`default_nettype none

module dsfp_back
    import dsfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output      logic        q_pop,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata    // frame_done[0], frame_protocol[2:1],
                                        // frame_length[11:3], read_data[19:12]
);

    // Per-port parser state.
    stage_t              stage_reg [PORTS];
    proto_t              proto_reg [PORTS];
    logic [WIDX_W-1:0]   widx_reg  [PORTS];
    logic [SIZE_W-1:0]   plen_reg  [PORTS];

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic                done_reg;
    proto_t              oproto_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                is_read_reg;

    logic                issue;
    logic                feed;
    stage_t              cur_stage, stage_next;
    proto_t              cur_proto, proto_next;
    logic [WIDX_W-1:0]   cur_widx,  widx_next;
    logic [SIZE_W-1:0]   cur_plen,  plen_next;
    logic [WIDX_W-1:0]   widx_inc;
    logic [SIZE_W-1:0]   size_word;
    logic                store_we;
    logic [ADDR_W-1:0]   store_waddr;
    logic                frame_done;
    logic [BYTE_W-1:0]   store_rdata;

    assign issue = q_valid && (!out_valid_reg || m_tready);
    assign q_pop = issue;
    assign feed  = issue && !q_cmd.is_read;

    assign cur_stage = stage_reg[q_cmd.port];
    assign cur_proto = proto_reg[q_cmd.port];
    assign cur_widx  = widx_reg[q_cmd.port];
    assign cur_plen  = plen_reg[q_cmd.port];
    assign widx_inc  = cur_widx + WIDX_W'(1);
    assign size_word = {q_cmd.value, cur_plen[BYTE_W-1:0]};

    // Next parser state for the addressed port.
    always_comb
    begin
        stage_next  = cur_stage;
        proto_next  = cur_proto;
        widx_next   = cur_widx;
        plen_next   = cur_plen;
        store_we    = 1'b0;
        store_waddr = {q_cmd.port, cur_widx[IDX_W-1:0]};
        frame_done  = 1'b0;
        unique case (cur_stage)
            ST_IDLE:
            begin
                if (q_cmd.value == SYNC_DB_A)
                begin
                    proto_next = PROTO_DB;
                    stage_next = ST_SYNC2;
                end
                else if (q_cmd.value == SYNC_UBX_A)
                begin
                    proto_next = PROTO_UBX;
                    stage_next = ST_SYNC2;
                end
            end
            ST_SYNC2:
            begin
                if ((cur_proto == PROTO_DB && q_cmd.value == SYNC_DB_B) ||
                    (cur_proto == PROTO_UBX && q_cmd.value == SYNC_UBX_B))
                begin
                    widx_next  = '0;
                    stage_next = ST_TYPE0;
                end
                else
                begin
                    stage_next = ST_IDLE;
                    proto_next = PROTO_NONE;
                end
            end
            ST_TYPE0:
            begin
                store_we    = 1'b1;
                store_waddr = {q_cmd.port, IDX_W'(0)};
                widx_next   = WIDX_W'(1);
                stage_next  = ST_TYPE1;
            end
            ST_TYPE1:
            begin
                store_we    = 1'b1;
                store_waddr = {q_cmd.port, IDX_W'(1)};
                widx_next   = WIDX_W'(2);
                stage_next  = ST_SIZE;
            end
            ST_SIZE:
            begin
                // Size bytes go to the store and also into the length register,
                // low byte first.
                store_we  = 1'b1;
                widx_next = widx_inc;
                if (widx_inc == WIDX_W'(4))
                begin
                    plen_next = size_word;
                    if (size_word > MAX_PAYLOAD)
                    begin
                        stage_next = ST_IDLE;
                        proto_next = PROTO_NONE;
                    end
                    else
                    begin
                        stage_next = ST_PAYLOAD;
                    end
                end
                else
                begin
                    plen_next = {cur_plen[SIZE_W-1:BYTE_W], q_cmd.value};
                end
            end
            ST_PAYLOAD:
            begin
                if (cur_widx >= WIDX_W'(FRAME_BYTES))
                begin
                    stage_next = ST_IDLE;
                    proto_next = PROTO_NONE;
                end
                else
                begin
                    store_we  = 1'b1;
                    widx_next = widx_inc;
                    if ({1'b0, cur_plen} + (SIZE_W + 1)'(FRAME_OVERHEAD) ==
                        (SIZE_W + 1)'(widx_inc))
                    begin
                        frame_done = 1'b1;
                        stage_next = ST_IDLE;
                        proto_next = PROTO_NONE;
                    end
                end
            end
            default:
            begin
                stage_next = ST_IDLE;
                proto_next = PROTO_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                stage_reg[i] <= ST_IDLE;
                proto_reg[i] <= PROTO_NONE;
                widx_reg[i]  <= '0;
                plen_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                if (feed && (q_cmd.port == PORT_W'(i)))
                begin
                    stage_reg[i] <= stage_next;
                    proto_reg[i] <= proto_next;
                    widx_reg[i]  <= widx_next;
                    plen_reg[i]  <= plen_next;
                end
            end
        end
    end

    dsfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (feed && store_we),
        .waddr (store_waddr),
        .wdata (q_cmd.value),
        .re    (issue && q_cmd.is_read),
        .raddr ({q_cmd.port, q_cmd.value[IDX_W-1:0]}),
        .rdata (store_rdata)
    );

    assign out_valid_next = issue || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            is_read_reg <= q_cmd.is_read;
            done_reg    <= feed && frame_done;
            oproto_reg  <= (feed && frame_done) ? cur_proto : PROTO_NONE;
            len_reg     <= (feed && frame_done) ? LEN_W'(widx_inc) : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0,
                       is_read_reg ? store_rdata : {BYTE_W{1'b0}},
                       len_reg, oproto_reg, done_reg};

    a_done_has_proto: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (oproto_reg != PROTO_NONE))
        else $error("completed frame without a protocol");

    a_done_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |->
            (len_reg >= LEN_W'(FRAME_OVERHEAD) && len_reg <= LEN_W'(FRAME_BYTES)))
        else $error("completed frame length out of range");

    a_read_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_read_reg) |-> !done_reg)
        else $error("read request reported a frame");

    a_payload_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && cur_stage == ST_PAYLOAD) |->
            (cur_plen <= MAX_PAYLOAD &&
             (SIZE_W + 1)'(cur_widx) < {1'b0, cur_plen} + (SIZE_W + 1)'(FRAME_OVERHEAD)))
        else $error("payload stage with an invalid size or write offset");

    a_no_issue_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !q_pop)
        else $error("command issued while the result register is stalled");

endmodule

`default_nettype wire

>>> rtl/dual_sync_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// dual_sync_frame_parser_unit: four-port DB / UBX byte-stream frame parser
// Each port hunts for a 'd','b' or 0xB5,0x62 sync pair, then stores the two
// type bytes, the little-endian size, the payload and two checksum bytes in
// its own 256-byte slice of a frame store. The beat that completes a frame
// reports done, the protocol and the stored length; read beats return one
// stored byte.
//
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_tvalid / s_tready  tuser: req_type;
//                                             tdata: port, data_byte, read_index
//   m_*       out        m_tvalid / m_tready  tdata: frame_done, frame_protocol,
//                                             frame_length, read_data
//
// Every input beat yields exactly one output beat, in order. With no output
// stall the sustained rate is one beat per cycle. A beat accepted into the
// queue waits in an entry until the back end pops it, and the parser update
// and the registered frame store read then load its result into the output
// register, from which m_tdata presents it until it is taken.
// The per-port parser state is read, updated and written back as each beat is
// popped, so beats for the same port may follow each other without a gap.
// A two-entry command queue absorbs one beat during an output stall. s_tready
// is low whenever both entries are full, which happens in the cycle after any
// output stall that meets a steady input stream, and it stays low until the
// back end pops again.
// Reset clears every port's parser to idle; the frame store is not cleared,
// and bytes of it that were never written read back as unknown values.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_sync_frame_parser_unit
    import dsfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // port[1:0], data_byte[9:2], read_index[17:10]
    input  wire logic        s_tuser,   // req_type: 0 received byte, 1 store read
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata    // frame_done[0], frame_protocol[2:1],
                                        // frame_length[11:3], read_data[19:12]
);

    // Classified commands flow from the front queue to the back end.
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    dsfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    // The back end pops a command only when its result register is free or is
    // being emptied in the same cycle, so no result is ever overwritten.
    dsfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
